FILE: design/assert_macros.svh
// Assertion helpers, used by pcx_seq.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that expr never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: design/pcx_pkg.sv
`timescale 1ns / 1ps
package pcx_pkg;

  localparam int TOTAL_W = 25;
  localparam int RUN_W   = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd64000;
  localparam logic [7:0]         RUN_MARK    = 8'd192;

  typedef enum logic [1:0] {
    CMD_DATA      = 2'd0,
    CMD_PAL_WRITE = 2'd1,
    CMD_START     = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_blue;
    logic [7:0] palette_green;
    logic [7:0] palette_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       run_last;
    logic       image_done;
  } out_item_t;

  // One pixel handed from the sequencer to the output register.
  typedef struct packed {
    logic load;
    logic run_last;
    logic image_done;
    logic blank;
  } emit_t;

endpackage

FILE: design/pcx_ram.sv
`timescale 1ns / 1ps
module pcx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/pcx_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcx_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  pcx_pkg::in_item_t             in_item,
  input  logic                          in_range,
  input  logic [pcx_pkg::TOTAL_W-1:0]   pixel_total,
  input  logic                          slot_free,
  output logic                          in_stall,
  output pcx_pkg::emit_t                emit
);

  pcx_pkg::state_t state_r, state_nxt;
  logic [pcx_pkg::RUN_W-1:0]   rem_r, rem_nxt;
  logic [pcx_pkg::TOTAL_W-1:0] pe_r, pe_nxt;
  logic                        pending_r, pending_nxt;
  logic [pcx_pkg::RUN_W-1:0]   run_len_r, run_len_nxt;
  logic                        blank_r, blank_nxt;

  logic                        load;
  logic [pcx_pkg::TOTAL_W-1:0] pe_inc;
  logic                        pix_done;
  logic                        pix_last;
  logic                        accept;
  logic                        complete;
  logic                        is_data;
  logic                        is_start;
  logic                        go;
  logic [pcx_pkg::RUN_W-1:0]   emit_cnt;

  assign load     = (state_r == pcx_pkg::ST_EMIT) && slot_free;
  assign pe_inc   = pe_r + pcx_pkg::TOTAL_W'(1);
  assign pix_done = pe_inc >= pixel_total;
  assign pix_last = (rem_r == pcx_pkg::RUN_W'(1)) || pix_done;

  // FSM outputs
  always_comb begin
    in_stall        = 1'b0;
    emit.load       = load;
    emit.run_last   = pix_last;
    emit.image_done = pix_done;
    emit.blank      = blank_r;
    case (state_r)
      pcx_pkg::ST_IDLE: in_stall = 1'b0;
      pcx_pkg::ST_EMIT: in_stall = !(load && pix_last);
      default:          in_stall = 1'b0;
    endcase
  end

  assign accept   = in_valid && !in_stall;
  // A pixel loaded at this edge counts toward the total seen by the new transaction.
  assign complete = load ? pix_done : (pe_r >= pixel_total);
  assign is_data  = accept && (in_item.command == pcx_pkg::CMD_DATA) && !complete;
  assign is_start = accept && (in_item.command == pcx_pkg::CMD_START);

  always_comb begin
    go       = 1'b0;
    emit_cnt = pcx_pkg::RUN_W'(1);
    if (is_data) begin
      if (pending_r) begin
        emit_cnt = run_len_r;
        go       = (run_len_r != '0);
      end else if (in_item.data_byte < pcx_pkg::RUN_MARK) begin
        go = 1'b1;
      end
    end
  end

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcx_pkg::ST_IDLE: begin
        if (go) state_nxt = pcx_pkg::ST_EMIT;
      end
      pcx_pkg::ST_EMIT: begin
        if (load && pix_last) state_nxt = go ? pcx_pkg::ST_EMIT : pcx_pkg::ST_IDLE;
      end
      default: state_nxt = pcx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt     = rem_r;
    pe_nxt      = pe_r;
    pending_nxt = pending_r;
    run_len_nxt = run_len_r;
    blank_nxt   = blank_r;
    if (load) begin
      rem_nxt = rem_r - pcx_pkg::RUN_W'(1);
      pe_nxt  = pe_inc;
      if (pix_done) begin
        pending_nxt = 1'b0;
        run_len_nxt = '0;
      end
    end
    if (go) begin
      rem_nxt   = emit_cnt;
      blank_nxt = !in_range;
    end
    if (is_data) begin
      if (pending_r) begin
        pending_nxt = 1'b0;
        run_len_nxt = '0;
      end else if (in_item.data_byte >= pcx_pkg::RUN_MARK) begin
        pending_nxt = 1'b1;
        run_len_nxt = in_item.data_byte[pcx_pkg::RUN_W-1:0];
      end
    end
    if (is_start) begin
      pe_nxt      = '0;
      pending_nxt = 1'b0;
      run_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pcx_pkg::ST_IDLE;
      rem_r     <= '0;
      pe_r      <= '0;
      pending_r <= 1'b0;
      run_len_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rem_r     <= rem_nxt;
      pe_r      <= pe_nxt;
      pending_r <= pending_nxt;
      run_len_r <= run_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_r <= blank_nxt;
  end

  `ASSERT_NEVER(a_emit_rem_zero, clk, rst_n, (state_r == pcx_pkg::ST_EMIT) && (rem_r == '0))
  `ASSERT_PROP(a_done_is_last, clk, rst_n, (load && pix_done) |-> pix_last)
  `ASSERT_PROP(a_done_goes_idle, clk, rst_n, (load && pix_done) |=> (state_r == pcx_pkg::ST_IDLE))
  `ASSERT_PROP(a_done_clears_run, clk, rst_n, (load && pix_done) |=> !pending_r)

endmodule

FILE: design/pcx_rle_palette_decoder_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake         Payload
// in_      input      in_valid/in_stall   pcx_pkg::in_item_t
// out_     output     out_valid/out_stall pcx_pkg::out_item_t
// cfg_     input      cfg_valid/cfg_ready 25-bit pixel_total
//
// A literal byte is accepted with its palette read; its pixel then loads the output register
// from the registered RAM output once the slot is free. A run reads the palette once and
// holds that word for all of its pixels, with the input stalled until the last pixel loads.
// Markers, palette writes and start transactions are accepted without emitting a pixel.
// Reset clears the run state and pixel count and sets pixel_total to 64000; palette
// contents are unknown until written, with no clearing pass.
// out_stall holds the output register and, while the sequencer has a pixel to emit, the input.
module pcx_rle_palette_decoder_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pcx_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pcx_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pcx_pkg::TOTAL_W-1:0] cfg_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

  logic [pcx_pkg::TOTAL_W-1:0] pixel_total_r, pixel_total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pcx_pkg::out_item_t          out_item_r;

  logic           accept;
  logic           wr_range;
  logic           rd_range;
  logic           pal_we;
  logic           pal_re;
  logic [23:0]    pal_wdata;
  logic [23:0]    pal_rdata;
  logic [23:0]    color;
  logic           slot_free;
  pcx_pkg::emit_t emit;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign wr_range  = {1'b0, in_item.palette_index} < DEPTH_LIM;
  assign rd_range  = {1'b0, in_item.data_byte} < DEPTH_LIM;
  assign pal_we    = accept && (in_item.command == pcx_pkg::CMD_PAL_WRITE) && wr_range;
  assign pal_re    = accept && (in_item.command == pcx_pkg::CMD_DATA);
  assign pal_wdata = {in_item.palette_red, in_item.palette_green, in_item.palette_blue};

  pcx_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(in_item.palette_index[AW-1:0]),
    .wdata(pal_wdata),
    .re   (pal_re),
    .raddr(in_item.data_byte[AW-1:0]),
    .rdata(pal_rdata)
  );

  assign slot_free = !out_valid_r || !out_stall;

  pcx_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_range   (rd_range),
    .pixel_total(pixel_total_r),
    .slot_free  (slot_free),
    .in_stall   (in_stall),
    .emit       (emit)
  );

  // Out-of-range indexes read as black.
  assign color = emit.blank ? 24'd0 : pal_rdata;

  always_comb begin
    pixel_total_nxt = cfg_valid ? cfg_data : pixel_total_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_total_r <= pcx_pkg::TOTAL_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      pixel_total_r <= pixel_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_item_r.pixel_blue  <= color[7:0];
      out_item_r.pixel_green <= color[15:8];
      out_item_r.pixel_red   <= color[23:16];
      out_item_r.run_last    <= emit.run_last;
      out_item_r.image_done  <= emit.image_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
